/* rtl/core/rata_pkg.sv */
// rata_pkg: shared types, codes and constants of the rectangle/alpha tween animator
// no dependencies; used by rata_front, rata_div, rata_back and the top level
package rata_pkg;

    // default configuration
    localparam int COORD_WIDTH_DEF     = 24;
    localparam int STEP_WIDTH_DEF      = 16;
    localparam int COS_TABLE_DEPTH_DEF = 1024;

    // geometry of the channels
    localparam int NUM_CHAN  = 3;
    localparam int NUM_COORD = 4;

    // shared arithmetic units
    localparam int MUL_W = 33;
    localparam int DIV_N = 64;
    localparam int DIV_D = 32;

    // pi in Q30 and number of sine series correction terms
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam int          TERMS  = 6;

    // reciprocals of the series divisors are scaled by 2^RECIP_SHIFT
    localparam int RECIP_SHIFT = 35;

    // input mode codes
    localparam logic [2:0] MODE_TICK         = 3'd0;
    localparam logic [2:0] MODE_START_FRAME  = 3'd1;
    localparam logic [2:0] MODE_START_REGION = 3'd2;
    localparam logic [2:0] MODE_START_ALPHA  = 3'd3;
    localparam logic [2:0] MODE_FINISH       = 3'd4;

    // channel codes
    localparam logic [1:0] CH_FRAME  = 2'd0;
    localparam logic [1:0] CH_REGION = 2'd1;
    localparam logic [1:0] CH_ALPHA  = 2'd2;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_TICK,
        CMD_START,
        CMD_FINISH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [1:0] chan;
        logic       ease;
    } cmd_ctrl_t;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DIV_D-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_N-1:0] quotient;
    } div_rsp_t;

    // divisor of the k-th sine series term: (2k)(2k+1)
    function automatic logic [DIV_D-1:0] term_divisor(input logic [2:0] k);
        int kk;
        kk = int'(k);
        return DIV_D'((2 * kk) * (2 * kk + 1));
    endfunction

    // floor(2^RECIP_SHIFT / ((2k)(2k+1))), estimate is low by at most one
    function automatic logic [MUL_W-1:0] term_recip(input logic [2:0] k);
        logic [MUL_W-1:0] r;
        unique case (k)
            3'd1:    r = 33'd5726623061;
            3'd2:    r = 33'd1717986918;
            3'd3:    r = 33'd818089008;
            3'd4:    r = 33'd477218588;
            3'd5:    r = 33'd312361257;
            3'd6:    r = 33'd220254733;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/rata_front.sv */
// rata_front: input handshake, mode decode and two-entry command queue
// depends on rata_pkg
module rata_front #(
    parameter int COORD_WIDTH = rata_pkg::COORD_WIDTH_DEF,
    parameter int STEP_WIDTH  = rata_pkg::STEP_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_mode,
    input  logic signed [COORD_WIDTH-1:0]    s_start_x,
    input  logic signed [COORD_WIDTH-1:0]    s_start_y,
    input  logic signed [COORD_WIDTH-1:0]    s_start_w,
    input  logic signed [COORD_WIDTH-1:0]    s_start_h,
    input  logic signed [COORD_WIDTH-1:0]    s_end_x,
    input  logic signed [COORD_WIDTH-1:0]    s_end_y,
    input  logic signed [COORD_WIDTH-1:0]    s_end_w,
    input  logic signed [COORD_WIDTH-1:0]    s_end_h,
    input  logic [STEP_WIDTH-1:0]            s_step_total,
    input  logic                             s_ease_kind,
    output logic                             q_valid,
    output rata_pkg::cmd_ctrl_t              q_ctrl,
    output logic [4*COORD_WIDTH-1:0]         q_start,
    output logic [4*COORD_WIDTH-1:0]         q_end,
    output logic [STEP_WIDTH-1:0]            q_steps,
    input  logic                             q_pop
);

    localparam int DEPTH = 2;

    rata_pkg::cmd_ctrl_t      dec_ctrl;
    rata_pkg::cmd_ctrl_t      ctrl_mem_reg  [DEPTH];
    logic [4*COORD_WIDTH-1:0] start_mem_reg [DEPTH];
    logic [4*COORD_WIDTH-1:0] end_mem_reg   [DEPTH];
    logic [STEP_WIDTH-1:0]    steps_mem_reg [DEPTH];
    logic                     wr_ptr_reg;
    logic                     rd_ptr_reg;
    logic [1:0]               count_reg;
    logic                     push;
    logic                     pop;

    // classify the item by mode
    always_comb begin
        dec_ctrl.ease = s_ease_kind;
        unique case (s_mode)
            rata_pkg::MODE_TICK: begin
                dec_ctrl.kind = rata_pkg::CMD_TICK;
                dec_ctrl.chan = rata_pkg::CH_FRAME;
            end
            rata_pkg::MODE_START_FRAME: begin
                dec_ctrl.kind = rata_pkg::CMD_START;
                dec_ctrl.chan = rata_pkg::CH_FRAME;
            end
            rata_pkg::MODE_START_REGION: begin
                dec_ctrl.kind = rata_pkg::CMD_START;
                dec_ctrl.chan = rata_pkg::CH_REGION;
            end
            rata_pkg::MODE_START_ALPHA: begin
                dec_ctrl.kind = rata_pkg::CMD_START;
                dec_ctrl.chan = rata_pkg::CH_ALPHA;
            end
            rata_pkg::MODE_FINISH: begin
                dec_ctrl.kind = rata_pkg::CMD_FINISH;
                dec_ctrl.chan = rata_pkg::CH_FRAME;
            end
            default: begin
                dec_ctrl.kind = rata_pkg::CMD_NONE;
                dec_ctrl.chan = rata_pkg::CH_FRAME;
            end
        endcase
    end

    // unknown modes are accepted and dropped
    assign s_ready = (count_reg != 2'(DEPTH));
    assign push    = s_valid && s_ready && (dec_ctrl.kind != rata_pkg::CMD_NONE);
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_pop && q_valid;

    // queue pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            ctrl_mem_reg[wr_ptr_reg]  <= dec_ctrl;
            start_mem_reg[wr_ptr_reg] <= {s_start_h, s_start_w, s_start_y, s_start_x};
            end_mem_reg[wr_ptr_reg]   <= {s_end_h, s_end_w, s_end_y, s_end_x};
            steps_mem_reg[wr_ptr_reg] <= s_step_total;
        end
    end

    assign q_ctrl  = ctrl_mem_reg[rd_ptr_reg];
    assign q_start = start_mem_reg[rd_ptr_reg];
    assign q_end   = end_mem_reg[rd_ptr_reg];
    assign q_steps = steps_mem_reg[rd_ptr_reg];

endmodule

/* rtl/core/rata_div.sv */
// rata_div: shared unsigned restoring divider, one quotient bit per cycle
// depends on rata_pkg
module rata_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  rata_pkg::div_req_t req,
    output rata_pkg::div_rsp_t rsp
);

    localparam int N  = rata_pkg::DIV_N;
    localparam int D  = rata_pkg::DIV_D;
    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  quo_reg;
    logic [D-1:0]  rem_reg;
    logic [D-1:0]  divisor_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [D:0]    shifted;
    logic [D:0]    trial;

    // one restoring step
    assign shifted = {rem_reg, quo_reg[N-1]};
    assign trial   = shifted - {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                quo_reg     <= req.dividend;
                rem_reg     <= '0;
                divisor_reg <= req.divisor;
                cnt_reg     <= CW'(N);
                busy_reg    <= 1'b1;
            end else if (busy_reg) begin
                if (!trial[D]) begin
                    rem_reg <= trial[D-1:0];
                    quo_reg <= {quo_reg[N-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted[D-1:0];
                    quo_reg <= {quo_reg[N-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* rtl/core/rata_back.sv */
// rata_back: channel state, tween sequencer with shared multiplier, output register
// depends on rata_pkg; drives the shared divider rata_div
module rata_back #(
    parameter int COORD_WIDTH     = rata_pkg::COORD_WIDTH_DEF,
    parameter int STEP_WIDTH      = rata_pkg::STEP_WIDTH_DEF,
    parameter int COS_TABLE_DEPTH = rata_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  rata_pkg::cmd_ctrl_t           q_ctrl,
    input  logic [4*COORD_WIDTH-1:0]      q_start,
    input  logic [4*COORD_WIDTH-1:0]      q_end,
    input  logic [STEP_WIDTH-1:0]         q_steps,
    output logic                          q_pop,
    output rata_pkg::div_req_t            div_req,
    input  rata_pkg::div_rsp_t            div_rsp,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_channel,
    output logic signed [COORD_WIDTH-1:0] m_value_x,
    output logic signed [COORD_WIDTH-1:0] m_value_y,
    output logic signed [COORD_WIDTH-1:0] m_value_w,
    output logic signed [COORD_WIDTH-1:0] m_value_h,
    output logic                          m_ended,
    output logic                          m_last
);

    localparam int CW  = COORD_WIDTH;
    localparam int SW  = STEP_WIDTH;
    localparam int MW  = rata_pkg::MUL_W;
    localparam int NC  = rata_pkg::NUM_CHAN;
    localparam int NK  = rata_pkg::NUM_COORD;
    localparam int PW  = $clog2(COS_TABLE_DEPTH);
    localparam int DN  = rata_pkg::DIV_N;
    localparam int DD  = rata_pkg::DIV_D;
    // table depth is a power of two, so the half angle scale is a shift
    localparam int AS  = $clog2(2 * COS_TABLE_DEPTH);
    localparam int RS  = rata_pkg::RECIP_SHIFT;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_MUL, S_PROD, S_DIV, S_EMIT, S_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_P, OP_A, OP_A2, OP_TERM, OP_RCP, OP_CHK, OP_E, OP_VAL
    } op_t;

    state_t          state_reg;
    op_t             op_reg;
    logic [1:0]      ch_reg;
    logic [1:0]      idx_reg;
    logic [2:0]      k_reg;
    logic            fin_reg;
    logic [NC-1:0]   fin_mask_reg;
    logic [NC-1:0]   active_reg;
    logic            ease_reg;
    logic [CW-1:0]   from_reg [NC][NK];
    logic [CW-1:0]   to_reg   [NC][NK];
    logic [SW-1:0]   pos_reg  [NC];
    logic [SW-1:0]   len_reg  [NC];
    logic [PW-1:0]   p_reg;
    logic [31:0]     a_reg;
    logic [31:0]     a2_reg;
    logic [31:0]     term_reg;
    logic [31:0]     sum_reg;
    logic [MW-1:0]   tx_reg;
    logic [31:0]     qe_reg;
    logic [16:0]     e_reg;
    logic [2*MW-1:0] prod_reg;
    logic [CW-1:0]   val_reg  [NK];
    logic            ended_reg;
    logic            m_valid_reg;
    logic [1:0]      m_channel_reg;
    logic [CW-1:0]   m_value_reg [NK];
    logic            m_ended_reg;
    logic            m_last_reg;

    logic [NC-1:0]   report;
    logic            later_report;
    logic            later_fin;
    logic [2:0]      n_coord;
    logic [SW-1:0]   cur_pos;
    logic [SW-1:0]   cur_len;
    logic            forced;
    logic signed [CW:0] diff;
    logic signed [CW:0] diff_neg;
    logic            diff_sign;
    logic [CW-1:0]   mag;
    logic [CW-1:0]   q_val;
    logic [CW-1:0]   new_val;
    logic [MW-1:0]   mul_a;
    logic [MW-1:0]   mul_b;
    logic [2*MW:0]   e_round;
    logic [MW-1:0]   chk_rem;
    logic [31:0]     term_q;
    logic            emit_free;
    logic            idx_last;

    // per-channel status
    always_comb begin
        later_report = 1'b0;
        later_fin    = 1'b0;
        for (int c = 0; c < NC; c++) begin
            report[c] = active_reg[c] && (pos_reg[c] < len_reg[c]);
            if (c > int'(ch_reg)) begin
                later_report = later_report | report[c];
                later_fin    = later_fin | fin_mask_reg[c];
            end
        end
    end

    assign n_coord  = (ch_reg == rata_pkg::CH_ALPHA) ? 3'd1 : 3'(NK);
    assign cur_pos  = pos_reg[ch_reg];
    assign cur_len  = len_reg[ch_reg];
    assign forced   = (cur_pos == cur_len - SW'(1));
    assign idx_last = ({1'b0, idx_reg} == n_coord - 3'd1);

    // signed difference of the current coordinate and its magnitude
    assign diff      = {to_reg[ch_reg][idx_reg][CW-1], to_reg[ch_reg][idx_reg]}
                     - {from_reg[ch_reg][idx_reg][CW-1], from_reg[ch_reg][idx_reg]};
    assign diff_neg  = -diff;
    assign diff_sign = diff[CW];
    assign mag       = diff_sign ? diff_neg[CW-1:0] : diff[CW-1:0];

    // scaled step: product shift for ease, divider quotient for linear
    assign q_val   = ease_reg ? prod_reg[16 +: CW] : div_rsp.quotient[CW-1:0];
    assign new_val = from_reg[ch_reg][idx_reg] + (diff_sign ? (~q_val + CW'(1)) : q_val);

    // rounding of the squared sine into the Q16 ease factor
    assign e_round = {1'b0, prod_reg} + ((2*MW+1)'(1) << 43);

    // series term quotient: reciprocal estimate plus one remainder check
    assign chk_rem = tx_reg - prod_reg[MW-1:0];
    assign term_q  = qe_reg + ((chk_rem >= MW'(rata_pkg::term_divisor(k_reg))) ? 32'd1
                                                                               : 32'd0);

    // shared multiplier operands
    always_comb begin
        unique case (op_reg)
            OP_P: begin
                mul_a = MW'(cur_pos);
                mul_b = MW'(COS_TABLE_DEPTH);
            end
            OP_A: begin
                mul_a = MW'(rata_pkg::PI_Q30);
                mul_b = MW'(p_reg);
            end
            OP_A2: begin
                mul_a = MW'(a_reg);
                mul_b = MW'(a_reg);
            end
            OP_TERM: begin
                mul_a = MW'(term_reg);
                mul_b = MW'(a2_reg);
            end
            OP_RCP: begin
                mul_a = tx_reg;
                mul_b = rata_pkg::term_recip(k_reg);
            end
            OP_CHK: begin
                mul_a = MW'(qe_reg);
                mul_b = MW'(rata_pkg::term_divisor(k_reg));
            end
            OP_E: begin
                mul_a = MW'(sum_reg);
                mul_b = MW'(sum_reg);
            end
            OP_VAL: begin
                mul_a = MW'(mag);
                mul_b = ease_reg ? MW'(e_reg) : MW'(cur_pos);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider request, only for divisions by the step count
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg[DN-1:0];
        div_req.divisor  = DD'(cur_len);
        if (state_reg == S_PROD) begin
            unique case (op_reg)
                OP_P:    div_req.start = 1'b1;
                OP_VAL:  div_req.start = !ease_reg;
                default: div_req.start = 1'b0;
            endcase
        end
    end

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign emit_free = !m_valid_reg || m_ready;

    // sequencer, channel state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_P;
            ch_reg       <= 2'd0;
            idx_reg      <= 2'd0;
            k_reg        <= 3'd0;
            fin_reg      <= 1'b0;
            fin_mask_reg <= '0;
            active_reg   <= '0;
            ease_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int c = 0; c < NC; c++) begin
                pos_reg[c] <= '0;
                len_reg[c] <= '0;
            end
        end else begin
            if (m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        unique case (q_ctrl.kind)
                            rata_pkg::CMD_TICK: begin
                                fin_reg   <= 1'b0;
                                ch_reg    <= 2'd0;
                                state_reg <= S_SCAN;
                            end
                            rata_pkg::CMD_START: begin
                                if (pos_reg[q_ctrl.chan] == len_reg[q_ctrl.chan]) begin
                                    for (int i = 0; i < NK; i++) begin
                                        from_reg[q_ctrl.chan][i] <= q_start[i*CW +: CW];
                                        to_reg[q_ctrl.chan][i]   <= q_end[i*CW +: CW];
                                    end
                                    pos_reg[q_ctrl.chan]    <= '0;
                                    len_reg[q_ctrl.chan]    <= q_steps;
                                    ease_reg                <= q_ctrl.ease;
                                    active_reg[q_ctrl.chan] <= 1'b1;
                                end
                            end
                            rata_pkg::CMD_FINISH: begin
                                fin_reg      <= 1'b1;
                                fin_mask_reg <= active_reg;
                                active_reg   <= '0;
                                for (int c = 0; c < NC; c++) pos_reg[c] <= len_reg[c];
                                ch_reg       <= 2'd0;
                                state_reg    <= S_FIN;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    for (int i = 0; i < NK; i++) begin
                        val_reg[i] <= (forced && (i < int'(n_coord))) ? to_reg[ch_reg][i] : '0;
                    end
                    ended_reg <= forced;
                    idx_reg   <= 2'd0;
                    op_reg    <= ease_reg ? OP_P : OP_VAL;
                    if (report[ch_reg]) begin
                        state_reg <= forced ? S_EMIT : S_MUL;
                    end else if (ch_reg == rata_pkg::CH_ALPHA) begin
                        state_reg <= S_IDLE;
                    end else begin
                        ch_reg <= ch_reg + 2'd1;
                    end
                end
                S_FIN: begin
                    for (int i = 0; i < NK; i++) begin
                        val_reg[i] <= (i < int'(n_coord)) ? to_reg[ch_reg][i] : '0;
                    end
                    ended_reg <= 1'b0;
                    if (fin_mask_reg[ch_reg]) begin
                        state_reg <= S_EMIT;
                    end else if (ch_reg == rata_pkg::CH_ALPHA) begin
                        state_reg <= S_IDLE;
                    end else begin
                        ch_reg <= ch_reg + 2'd1;
                    end
                end
                S_MUL: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_PROD;
                end
                S_PROD: begin
                    unique case (op_reg)
                        OP_A: begin
                            // half angle: divide by twice the table depth
                            a_reg     <= prod_reg[AS +: 32];
                            term_reg  <= prod_reg[AS +: 32];
                            sum_reg   <= prod_reg[AS +: 32];
                            op_reg    <= OP_A2;
                            state_reg <= S_MUL;
                        end
                        OP_A2: begin
                            a2_reg    <= prod_reg[61:30];
                            k_reg     <= 3'd1;
                            op_reg    <= OP_TERM;
                            state_reg <= S_MUL;
                        end
                        OP_TERM: begin
                            tx_reg    <= prod_reg[30 +: MW];
                            op_reg    <= OP_RCP;
                            state_reg <= S_MUL;
                        end
                        OP_RCP: begin
                            qe_reg    <= {1'b0, prod_reg[RS +: 31]};
                            op_reg    <= OP_CHK;
                            state_reg <= S_MUL;
                        end
                        OP_CHK: begin
                            term_reg <= term_q;
                            // odd terms subtract, even terms add
                            sum_reg  <= k_reg[0] ? sum_reg - term_q : sum_reg + term_q;
                            op_reg   <= (k_reg == 3'(rata_pkg::TERMS)) ? OP_E : OP_TERM;
                            k_reg     <= k_reg + 3'd1;
                            state_reg <= S_MUL;
                        end
                        OP_E: begin
                            e_reg     <= e_round[60:44];
                            idx_reg   <= 2'd0;
                            op_reg    <= OP_VAL;
                            state_reg <= S_MUL;
                        end
                        OP_VAL: begin
                            if (ease_reg) begin
                                val_reg[idx_reg] <= new_val;
                                idx_reg          <= idx_reg + 2'd1;
                                state_reg        <= idx_last ? S_EMIT : S_MUL;
                            end else begin
                                state_reg <= S_DIV;
                            end
                        end
                        default: state_reg <= S_DIV;
                    endcase
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        unique case (op_reg)
                            OP_P: begin
                                p_reg     <= div_rsp.quotient[PW-1:0];
                                op_reg    <= OP_A;
                                state_reg <= S_MUL;
                            end
                            OP_VAL: begin
                                val_reg[idx_reg] <= new_val;
                                idx_reg          <= idx_reg + 2'd1;
                                state_reg        <= idx_last ? S_EMIT : S_MUL;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_EMIT: begin
                    if (emit_free) begin
                        m_valid_reg   <= 1'b1;
                        m_channel_reg <= ch_reg;
                        for (int i = 0; i < NK; i++) m_value_reg[i] <= val_reg[i];
                        m_ended_reg   <= ended_reg;
                        m_last_reg    <= fin_reg ? !later_fin : !later_report;
                        if (!fin_reg) begin
                            pos_reg[ch_reg] <= cur_pos + SW'(1);
                            if (ended_reg) active_reg[ch_reg] <= 1'b0;
                        end
                        if (ch_reg == rata_pkg::CH_ALPHA) begin
                            state_reg <= S_IDLE;
                        end else begin
                            ch_reg    <= ch_reg + 2'd1;
                            state_reg <= fin_reg ? S_FIN : S_SCAN;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_channel = m_channel_reg;
    assign m_value_x = $signed(m_value_reg[0]);
    assign m_value_y = $signed(m_value_reg[1]);
    assign m_value_w = $signed(m_value_reg[2]);
    assign m_value_h = $signed(m_value_reg[3]);
    assign m_ended   = m_ended_reg;
    assign m_last    = m_last_reg;

`ifndef SYNTH
    // the divider is only started while idle
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // a quotient only arrives while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("quotient arrived outside the divide wait");

    // a finish leaves every channel idle
    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && (q_ctrl.kind == rata_pkg::CMD_FINISH)) |=> (active_reg == '0))
        else $error("channel still active after finish");

    // an emit with a free output slot always presents a result
    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_EMIT) && emit_free) |=> m_valid_reg)
        else $error("emitted result not presented");
`endif

endmodule

/* rtl/core/rect_alpha_tween_animator.sv */
// rect_alpha_tween_animator: top level of the three-channel tween animator
// depends on rata_pkg, rata_front, rata_div and rata_back
//
//   channel   ports         direction  per item
//   input     s_*, s_valid  in         one command (tick, start, finish)
//   result    m_*, m_valid  out        one channel value, up to three per item
//
// Start items are taken by the back end in its idle state; a finish visits every channel
// in turn and emits a value for each one that was active. A tick runs one shared divide
// per coordinate of a linear channel and one divide plus a sine series per eased one.
// Two command slots sit between front and back; the front keeps accepting while a slot
// is free, also while the back works or its output register waits. Reset is synchronous,
// active low, and leaves every channel idle with linear ease.
module rect_alpha_tween_animator #(
    parameter int COORD_WIDTH     = rata_pkg::COORD_WIDTH_DEF,
    parameter int STEP_WIDTH      = rata_pkg::STEP_WIDTH_DEF,
    parameter int COS_TABLE_DEPTH = rata_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_mode,
    input  logic signed [COORD_WIDTH-1:0] s_start_x,
    input  logic signed [COORD_WIDTH-1:0] s_start_y,
    input  logic signed [COORD_WIDTH-1:0] s_start_w,
    input  logic signed [COORD_WIDTH-1:0] s_start_h,
    input  logic signed [COORD_WIDTH-1:0] s_end_x,
    input  logic signed [COORD_WIDTH-1:0] s_end_y,
    input  logic signed [COORD_WIDTH-1:0] s_end_w,
    input  logic signed [COORD_WIDTH-1:0] s_end_h,
    input  logic [STEP_WIDTH-1:0]         s_step_total,
    input  logic                          s_ease_kind,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_channel,
    output logic signed [COORD_WIDTH-1:0] m_value_x,
    output logic signed [COORD_WIDTH-1:0] m_value_y,
    output logic signed [COORD_WIDTH-1:0] m_value_w,
    output logic signed [COORD_WIDTH-1:0] m_value_h,
    output logic                          m_ended,
    output logic                          m_last
);

    logic                     q_valid;
    logic                     q_pop;
    rata_pkg::cmd_ctrl_t      q_ctrl;
    logic [4*COORD_WIDTH-1:0] q_start;
    logic [4*COORD_WIDTH-1:0] q_end;
    logic [STEP_WIDTH-1:0]    q_steps;
    rata_pkg::div_req_t       div_req;
    rata_pkg::div_rsp_t       div_rsp;

    // accept and classify items
    rata_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .STEP_WIDTH  (STEP_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_start_w    (s_start_w),
        .s_start_h    (s_start_h),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_end_w      (s_end_w),
        .s_end_h      (s_end_h),
        .s_step_total (s_step_total),
        .s_ease_kind  (s_ease_kind),
        .q_valid      (q_valid),
        .q_ctrl       (q_ctrl),
        .q_start      (q_start),
        .q_end        (q_end),
        .q_steps      (q_steps),
        .q_pop        (q_pop)
    );

    // shared divider
    rata_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // tween engine
    rata_back #(
        .COORD_WIDTH     (COORD_WIDTH),
        .STEP_WIDTH      (STEP_WIDTH),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ctrl    (q_ctrl),
        .q_start   (q_start),
        .q_end     (q_end),
        .q_steps   (q_steps),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_channel (m_channel),
        .m_value_x (m_value_x),
        .m_value_y (m_value_y),
        .m_value_w (m_value_w),
        .m_value_h (m_value_h),
        .m_ended   (m_ended),
        .m_last    (m_last)
    );

endmodule
